>>> hw/rtl/shsld_pkg.sv
`default_nettype none

package shsld_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    localparam cfg_index_t REG_DRIVE_LIMIT  = 3'd0;
    localparam cfg_index_t REG_UPPER_LIMIT  = 3'd1;
    localparam cfg_index_t REG_LOWER_LIMIT  = 3'd2;
    localparam cfg_index_t REG_HOMING_DRIVE = 3'd3;
    localparam cfg_index_t REG_STALL_SPEED  = 3'd4;
    localparam cfg_index_t REG_STALL_TICKS  = 3'd5;

    typedef struct packed {
        logic [9:0]         drive_limit;
        logic signed [15:0] upper_limit;
        logic signed [15:0] lower_limit;
        logic [9:0]         homing_drive;
        logic [14:0]        stall_speed;
        logic [7:0]         stall_ticks;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        drive_limit:  10'd400,
        upper_limit:  16'sd1650,
        lower_limit:  -16'sd10,
        homing_drive: 10'd100,
        stall_speed:  15'd50,
        stall_ticks:  8'd50
    };

    typedef enum logic [1:0] {
        MODE_HOMING,
        MODE_FINISH,
        MODE_RUN
    } drive_mode_t;

    // What travels beside the position through the scaling stages.
    typedef struct packed {
        drive_mode_t        mode;
        logic signed [15:0] cmd;
    } tick_ctrl_t;

    localparam logic signed [15:0] SCALED_MAX = 16'sh7FFF;
    localparam logic signed [15:0] SCALED_MIN = 16'sh8000;

endpackage

`default_nettype wire

>>> hw/rtl/shsld_cfg.sv
`default_nettype none

module shsld_cfg (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_we,
    input  wire shsld_pkg::cfg_index_t             cfg_index,
    input  wire logic [shsld_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output shsld_pkg::cfg_t                        cfg
);

    shsld_pkg::cfg_t cfg_reg;
    shsld_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                shsld_pkg::REG_DRIVE_LIMIT:  cfg_next.drive_limit  = cfg_wdata[9:0];
                shsld_pkg::REG_UPPER_LIMIT:  cfg_next.upper_limit  = cfg_wdata[15:0];
                shsld_pkg::REG_LOWER_LIMIT:  cfg_next.lower_limit  = cfg_wdata[15:0];
                shsld_pkg::REG_HOMING_DRIVE: cfg_next.homing_drive = cfg_wdata[9:0];
                shsld_pkg::REG_STALL_SPEED:  cfg_next.stall_speed  = cfg_wdata[14:0];
                shsld_pkg::REG_STALL_TICKS:  cfg_next.stall_ticks  = cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= shsld_pkg::CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> hw/rtl/shsld_tracker.sv
`default_nettype none

module shsld_tracker #(
    parameter int POSITION_BITS = 40
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             accept,
    input  wire logic signed [15:0]               delta,
    input  wire logic signed [15:0]               cmd,
    input  wire shsld_pkg::cfg_t                  cfg,
    output logic signed [POSITION_BITS-1:0]       sum_reg,
    output shsld_pkg::tick_ctrl_t                 ctrl_reg
);

    logic signed [POSITION_BITS-1:0] acc_reg;
    logic signed [POSITION_BITS-1:0] acc_next;
    logic                            done_reg;
    logic                            done_next;
    logic [7:0]                      stall_reg;
    logic [7:0]                      stall_next;

    logic signed [POSITION_BITS-1:0] sum;
    logic signed [16:0]              delta_wide;
    logic [16:0]                     speed;
    logic [7:0]                      stall_bumped;
    logic                            finish;
    shsld_pkg::drive_mode_t          mode;

    assign sum        = acc_reg + POSITION_BITS'(delta);
    assign delta_wide = 17'(delta);
    // The most negative delta gives 32768, which is never below the threshold.
    assign speed      = delta_wide[16] ? 17'(-delta_wide) : 17'(delta_wide);

    always_comb begin
        stall_bumped = (speed < {2'b00, cfg.stall_speed}) ? stall_reg + 8'd1 : 8'd0;
        finish       = !done_reg && (stall_bumped > cfg.stall_ticks);
        acc_next     = acc_reg;
        done_next    = done_reg;
        stall_next   = stall_reg;
        mode         = shsld_pkg::MODE_RUN;
        if (accept) begin
            acc_next = finish ? '0 : sum;
            if (!done_reg) begin
                stall_next = finish ? 8'd0 : stall_bumped;
                done_next  = finish;
            end
        end
        if (!done_reg) begin
            mode = finish ? shsld_pkg::MODE_FINISH : shsld_pkg::MODE_HOMING;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg   <= '0;
            done_reg  <= 1'b0;
            stall_reg <= 8'd0;
        end else begin
            acc_reg   <= acc_next;
            done_reg  <= done_next;
            stall_reg <= stall_next;
        end
    end

    // The scaled position is formed from the sum before any homing zeroing.
    always_ff @(posedge aclk) begin
        if (accept) begin
            sum_reg       <= sum;
            ctrl_reg.mode <= mode;
            ctrl_reg.cmd  <= cmd;
        end
    end

    a_done_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> done_reg)
        else $error("calibration was lost after homing finished");

    a_count_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> stall_reg == 8'd0)
        else $error("stall counter moved after calibration");

endmodule

`default_nettype wire

>>> hw/rtl/shsld_scaler.sv
`default_nettype none

module shsld_scaler #(
    parameter int POSITION_BITS = 40,
    parameter int SCALE_DIVISOR = 1000
) (
    input  wire logic                              aclk,
    input  wire logic                              load_mag,
    input  wire logic                              load_quot,
    input  wire logic signed [POSITION_BITS-1:0]   sum,
    output logic signed [15:0]                     scaled
);

    localparam int EXT_W     = (POSITION_BITS > 48) ? POSITION_BITS : 48;
    // Below saturation the magnitude is under 32768 * divisor, so 31 bits.
    localparam int MAG_BITS  = 31;
    localparam int QUOT_BITS = 15;
    localparam int SHIFT     = MAG_BITS + $clog2(SCALE_DIVISOR);
    localparam longint SAT_LIMIT  = longint'(SCALE_DIVISOR) * longint'(32768);
    localparam longint RECIP_FULL =
        ((longint'(1) <<< SHIFT) + longint'(SCALE_DIVISOR) - longint'(1))
        / longint'(SCALE_DIVISOR);
    localparam logic [32:0]             RECIP  = 33'(RECIP_FULL);
    localparam logic signed [EXT_W-1:0] SAT_HI = EXT_W'(SAT_LIMIT);
    localparam logic signed [EXT_W-1:0] SAT_LO = -SAT_HI;

    logic signed [EXT_W-1:0] sum_ext;
    logic signed [EXT_W-1:0] sum_abs;

    logic                    sat_hi_reg;
    logic                    sat_lo_reg;
    logic                    neg_reg;
    logic [MAG_BITS-1:0]     mag_reg;

    logic                    q_sat_hi_reg;
    logic                    q_sat_lo_reg;
    logic                    q_neg_reg;
    logic [QUOT_BITS-1:0]    quot_reg;

    logic [63:0]             product;
    logic signed [15:0]      quot_signed;

    assign sum_ext = EXT_W'(sum);
    assign sum_abs = sum_ext[EXT_W-1] ? -sum_ext : sum_ext;

    always_ff @(posedge aclk) begin
        if (load_mag) begin
            sat_hi_reg <= (sum_ext >= SAT_HI);
            sat_lo_reg <= (sum_ext <= SAT_LO);
            neg_reg    <= sum_ext[EXT_W-1];
            mag_reg    <= sum_abs[MAG_BITS-1:0];
        end
    end

    // Exact truncating division by a rounded-up reciprocal over 31-bit magnitudes.
    assign product = 64'(mag_reg) * 64'(RECIP);

    always_ff @(posedge aclk) begin
        if (load_quot) begin
            q_sat_hi_reg <= sat_hi_reg;
            q_sat_lo_reg <= sat_lo_reg;
            q_neg_reg    <= neg_reg;
            quot_reg     <= product[SHIFT +: QUOT_BITS];
        end
    end

    assign quot_signed = {1'b0, quot_reg};

    always_comb begin
        priority if (q_sat_hi_reg) begin
            scaled = shsld_pkg::SCALED_MAX;
        end else if (q_sat_lo_reg) begin
            scaled = shsld_pkg::SCALED_MIN;
        end else if (q_neg_reg) begin
            scaled = -quot_signed;
        end else begin
            scaled = quot_signed;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/shsld_drive.sv
`default_nettype none

module shsld_drive (
    input  wire logic                    aclk,
    input  wire logic                    load,
    input  wire shsld_pkg::tick_ctrl_t   ctrl,
    input  wire logic signed [15:0]      scaled,
    input  wire shsld_pkg::cfg_t         cfg,
    output logic [9:0]                   mag_reg,
    output logic                         forward_reg,
    output logic                         calibrated_reg,
    output logic signed [15:0]           position_reg
);

    logic        cmd_pos;
    logic        cmd_neg;
    logic        blocked;
    logic [15:0] cmd_abs;
    logic [9:0]  clamped;
    logic [9:0]  mag_next;
    logic        forward_next;
    logic        calibrated_next;

    assign cmd_neg = ctrl.cmd[15];
    assign cmd_pos = !ctrl.cmd[15] && (ctrl.cmd != 16'sd0);
    assign cmd_abs = cmd_neg ? 16'(-ctrl.cmd) : 16'(ctrl.cmd);
    assign clamped = (cmd_abs > {6'b000000, cfg.drive_limit}) ? cfg.drive_limit
                                                              : cmd_abs[9:0];

    // Above the upper limit only the upper check applies.
    always_comb begin
        priority if ($signed(scaled) > $signed(cfg.upper_limit)) begin
            blocked = cmd_pos;
        end else if ($signed(scaled) < $signed(cfg.lower_limit)) begin
            blocked = cmd_neg;
        end else begin
            blocked = 1'b0;
        end
    end

    always_comb begin
        unique case (ctrl.mode)
            shsld_pkg::MODE_HOMING: begin
                mag_next        = cfg.homing_drive;
                forward_next    = 1'b0;
                calibrated_next = 1'b0;
            end
            shsld_pkg::MODE_FINISH: begin
                mag_next        = 10'd0;
                forward_next    = 1'b0;
                calibrated_next = 1'b1;
            end
            shsld_pkg::MODE_RUN: begin
                mag_next        = blocked ? 10'd0 : clamped;
                forward_next    = cmd_pos && (mag_next != 10'd0);
                calibrated_next = 1'b1;
            end
            default: begin
                mag_next        = 10'd0;
                forward_next    = 1'b0;
                calibrated_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            mag_reg        <= mag_next;
            forward_reg    <= forward_next;
            calibrated_reg <= calibrated_next;
            position_reg   <= scaled;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/stall_homing_soft_limit_drive_unit.sv
// Stall-homing drive with soft position limits, one beat per control tick.
// Slave channel: s_tdata carries encoder_delta in [15:0] and drive_command
// in [31:16]. Master channel: m_tdata carries drive_magnitude [9:0],
// drive_forward [10], calibrated [11] and scaled_position [27:12]. The user
// must write registers via cfg_we / cfg_index / cfg_wdata only while idle;
// the block does not enforce it. Beats pass the tracker, scaler magnitude,
// scaler quotient and drive output registers. The position accumulator
// and the stall counter close their loops through a single register, and
// the divide by the scale is a reciprocal multiply in its own stage. After
// reset the accumulator, stall counter and calibration flag are cleared,
// the registers take their defaults, and the block starts homing: it
// drives in reverse until the end stop is found. One beat is accepted per
// cycle; when the receiver stalls, the result waits in the output register
// and new beats are still taken until every stage in front of it is full.
`default_nettype none

module stall_homing_soft_limit_drive_unit #(
    parameter int POSITION_BITS = 40,
    parameter int SCALE_DIVISOR = 1000
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    // [15:0] encoder_delta, [31:16] drive_command
    input  wire logic [31:0]                           s_tdata,
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    // [9:0] drive_magnitude, [10] drive_forward, [11] calibrated,
    // [27:12] scaled_position, [31:28] zero
    output logic [31:0]                                m_tdata,
    input  wire logic                                  cfg_we,
    input  wire shsld_pkg::cfg_index_t                 cfg_index,
    input  wire logic [shsld_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    shsld_pkg::cfg_t                 cfg;
    shsld_pkg::tick_ctrl_t           ctrl1;
    shsld_pkg::tick_ctrl_t           ctrl2_reg;
    shsld_pkg::tick_ctrl_t           ctrl3_reg;
    logic signed [POSITION_BITS-1:0] sum1;
    logic signed [15:0]              scaled;

    logic v1_reg;
    logic v2_reg;
    logic v3_reg;
    logic out_valid_reg;
    logic out_en;
    logic en3;
    logic en2;
    logic en1;
    logic accept;

    logic [9:0]         drive_mag;
    logic               drive_fwd;
    logic               calibrated;
    logic signed [15:0] position;

    // Each stage loads when it is empty or its beat moves on.
    assign out_en   = !out_valid_reg || m_tready;
    assign en3      = !v3_reg || out_en;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign s_tready = en1;
    assign accept   = s_tvalid && en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (en1) begin
                v1_reg <= s_tvalid;
            end
            if (en2) begin
                v2_reg <= v1_reg;
            end
            if (en3) begin
                v3_reg <= v2_reg;
            end
            if (out_en) begin
                out_valid_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en2) begin
            ctrl2_reg <= ctrl1;
        end
        if (en3) begin
            ctrl3_reg <= ctrl2_reg;
        end
    end

    shsld_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    shsld_tracker #(
        .POSITION_BITS (POSITION_BITS)
    ) u_tracker (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .delta    (s_tdata[15:0]),
        .cmd      (s_tdata[31:16]),
        .cfg      (cfg),
        .sum_reg  (sum1),
        .ctrl_reg (ctrl1)
    );

    shsld_scaler #(
        .POSITION_BITS (POSITION_BITS),
        .SCALE_DIVISOR (SCALE_DIVISOR)
    ) u_scaler (
        .aclk      (aclk),
        .load_mag  (en2),
        .load_quot (en3),
        .sum       (sum1),
        .scaled    (scaled)
    );

    shsld_drive u_drive (
        .aclk           (aclk),
        .load           (out_en),
        .ctrl           (ctrl3_reg),
        .scaled         (scaled),
        .cfg            (cfg),
        .mag_reg        (drive_mag),
        .forward_reg    (drive_fwd),
        .calibrated_reg (calibrated),
        .position_reg   (position)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, position, calibrated, drive_fwd, drive_mag};

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while the output register is empty");

    a_accept_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> v1_reg)
        else $error("accepted beat did not enter the first stage");

    a_homing_reverse: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[11] |-> !m_tdata[10])
        else $error("forward drive reported while homing");

    a_forward_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[10] |-> m_tdata[9:0] != 10'd0)
        else $error("forward flag set with zero drive");

endmodule

`default_nettype wire

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int IDLE_RX_HEAVY = 0;
    localparam int IDLE_TX_HEAVY = 1;
    localparam int IDLE_NONE     = 2;

    // Result beat as it sits in m_tdata, highest bits first.
    typedef struct packed {
        logic [3:0]         pad;
        logic signed [15:0] scaled_position;
        logic               calibrated;
        logic               drive_forward;
        logic [9:0]         drive_magnitude;
    } drive_result_t;

    class drive_scoreboard;
        shsld_pkg::cfg_t    regs;
        logic signed [39:0] position_acc;
        bit                 homed;
        logic [7:0]         stall_cnt;
        drive_result_t      expected_drive_q[$];
        int                 mismatches;
        int                 results_checked;
        int                 homing_ticks;
        int                 saturated_ticks;

        function new();
            regs         = shsld_pkg::CFG_RESET;
            position_acc = '0;
            homed        = 1'b0;
            stall_cnt    = '0;
        endfunction

        function int scaled_now();
            longint q;
            q = longint'(position_acc) / 1000;
            if (q > 32767) q = 32767;
            if (q < -32768) q = -32768;
            return int'(q);
        endfunction

        function void note_tick(logic signed [15:0] delta, logic signed [15:0] cmd);
            int            scaled;
            int            drive;
            int            speed;
            int            limit;
            drive_result_t want;
            position_acc = position_acc + delta;
            scaled = scaled_now();
            if (scaled == 32767 || scaled == -32768) saturated_ticks++;
            if (!homed) begin
                homing_ticks++;
                speed = (delta < 0) ? -int'(delta) : int'(delta);
                drive = -int'(regs.homing_drive);
                if (speed < int'(regs.stall_speed)) stall_cnt = stall_cnt + 8'd1;
                else stall_cnt = '0;
                if (stall_cnt > regs.stall_ticks) begin
                    // End stop found: the position restarts from zero.
                    stall_cnt    = '0;
                    homed        = 1'b1;
                    position_acc = '0;
                    drive        = 0;
                end
            end else begin
                drive = cmd;
                limit = regs.drive_limit;
                if (scaled > regs.upper_limit) begin
                    if (drive > 0) drive = 0;
                end else if (scaled < regs.lower_limit) begin
                    if (drive < 0) drive = 0;
                end
                if (drive > limit) drive = limit;
                else if (drive < -limit) drive = -limit;
            end
            want.pad             = '0;
            want.scaled_position = scaled[15:0];
            want.calibrated      = homed;
            want.drive_forward   = (drive > 0);
            want.drive_magnitude = 10'((drive < 0) ? -drive : drive);
            expected_drive_q.push_back(want);
        endfunction

        function void check_result(drive_result_t got);
            drive_result_t want;
            if (expected_drive_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %h", got);
                return;
            end
            want = expected_drive_q.pop_front();
            results_checked++;
            if (got.pad !== want.pad || got.scaled_position !== want.scaled_position ||
                got.calibrated !== want.calibrated ||
                got.drive_forward !== want.drive_forward ||
                got.drive_magnitude !== want.drive_magnitude) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $write("result %0d (expected/actual): magnitude %0d/%0d forward %b/%b ",
                           results_checked, want.drive_magnitude, got.drive_magnitude,
                           want.drive_forward, got.drive_forward);
                    $display("calibrated %b/%b position %0d/%0d pad %h/%h",
                             want.calibrated, got.calibrated, want.scaled_position,
                             got.scaled_position, want.pad, got.pad);
                end
            end
        endfunction
    endclass

    logic                             aclk      = 1'b0;
    logic                             aresetn   = 1'b0;
    logic                             s_tvalid  = 1'b0;
    logic                             s_tready;
    logic [31:0]                      s_tdata   = '0;
    logic                             m_tvalid;
    logic                             m_tready  = 1'b0;
    logic [31:0]                      m_tdata;
    logic                             cfg_we    = 1'b0;
    shsld_pkg::cfg_index_t            cfg_index = shsld_pkg::REG_DRIVE_LIMIT;
    logic [shsld_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    int              idle_mode  = IDLE_RX_HEAVY;
    bit              want_hold  = 1'b0;
    bit              hold_taken = 1'b0;
    int              hold_left  = 0;
    int              settings_used = 0;
    drive_scoreboard sb = new();

    always #6 aclk = ~aclk;

    stall_homing_soft_limit_drive_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Receiver: random back-pressure, plus one long hold-off on request.
    always @(posedge aclk) begin
        if (want_hold && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = 300;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (idle_mode == IDLE_RX_HEAVY) begin
            m_tready <= ($urandom_range(99) >= 70);
        end else if (idle_mode == IDLE_TX_HEAVY) begin
            m_tready <= ($urandom_range(99) >= 14);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    task automatic send_tick(input logic signed [15:0] delta, input logic signed [15:0] cmd);
        int gap_pct;
        gap_pct = (idle_mode == IDLE_RX_HEAVY) ? 14 : (idle_mode == IDLE_TX_HEAVY) ? 70 : 0;
        while ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {cmd, delta};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_tick(delta, cmd);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.expected_drive_q.size() != 0) @(posedge aclk);
    endtask

    task automatic put_reg(input shsld_pkg::cfg_index_t idx,
                           input logic [shsld_pkg::CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
    endtask

    task automatic program_regs(input shsld_pkg::cfg_t c);
        put_reg(shsld_pkg::REG_DRIVE_LIMIT,  16'(c.drive_limit));
        put_reg(shsld_pkg::REG_UPPER_LIMIT,  16'(c.upper_limit));
        put_reg(shsld_pkg::REG_LOWER_LIMIT,  16'(c.lower_limit));
        put_reg(shsld_pkg::REG_HOMING_DRIVE, 16'(c.homing_drive));
        put_reg(shsld_pkg::REG_STALL_SPEED,  16'(c.stall_speed));
        put_reg(shsld_pkg::REG_STALL_TICKS,  16'(c.stall_ticks));
        cfg_we <= 1'b0;
        sb.regs = c;
        settings_used++;
    endtask

    function automatic logic signed [15:0] pick_command(int limit);
        int r;
        r = $urandom_range(99);
        if (r < 10) return 16'($urandom_range(1) ? limit : -limit);
        else if (r < 20) return 16'($urandom_range(1) ? limit + 1 : -limit - 1);
        else if (r < 30) return 16'(int'($urandom_range(2)) - 1);
        else if (r < 40) return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
        return 16'($urandom);
    endfunction

    function automatic logic signed [15:0] pick_delta();
        int r;
        r = $urandom_range(99);
        if (r < 70) return 16'(int'($urandom_range(5000)) - 2500);
        else if (r < 74) return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
        else if (r < 84) return '0;
        return 16'($urandom);
    endfunction

    initial begin
        shsld_pkg::cfg_t    setting;
        logic signed [15:0] delta;
        int                 pos;
        int                 r;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Homing at the reset settings: fast ticks clear the stall count.
        send_tick(16'sh7FFF, 16'sd0);
        send_tick(16'sh8000, 16'sh7FFF);
        send_tick(16'sd49, 16'sh8000);
        send_tick(-16'sd50, 16'sd1);
        drain();
        setting = shsld_pkg::CFG_RESET;
        setting.homing_drive = 10'd1023;
        setting.stall_speed  = 15'd0;
        setting.stall_ticks  = 8'd0;
        program_regs(setting);
        send_tick(16'sd0, -16'sd1);
        drain();
        // The stall count wraps at 256, so with this limit homing never ends.
        setting.homing_drive = 10'd613;
        setting.stall_speed  = 15'h7FFF;
        setting.stall_ticks  = 8'd255;
        program_regs(setting);
        send_tick(16'sh7FFF, 16'sd0);
        send_tick(16'sh7FFE, 16'sd0);
        // Long reverse travel pushes the scaled position into negative saturation.
        for (int i = 0; i < 1250; i++) begin
            if (i == 600) idle_mode = IDLE_TX_HEAVY;
            r = $urandom_range(99);
            if (r < 93) delta = 16'(-int'($urandom_range(32768, 27000)));
            else if (r < 95) delta = 16'sh8000;
            else delta = 16'($urandom);
            send_tick(delta, 16'($urandom));
        end

        drain();
        setting = shsld_pkg::CFG_RESET;
        setting.upper_limit  = 16'sd2;
        setting.lower_limit  = -16'sd2;
        setting.homing_drive = 10'd0;
        setting.stall_ticks  = 8'd2;
        program_regs(setting);
        send_tick(16'sd60, 16'sd0);
        send_tick(16'sd10, 16'sd0);
        send_tick(-16'sd49, 16'sd0);
        send_tick(16'sd0, 16'sd300);
        send_tick(16'sd5, 16'sh7FFF);
        send_tick(16'sd0, 16'sh8000);
        send_tick(16'sd0, 16'sd0);
        send_tick(16'sh7FFF, 16'sd100);
        send_tick(16'sd0, -16'sd100);
        send_tick(16'sh8000, -16'sd50);
        send_tick(16'sh8000, -16'sd50);
        send_tick(16'sd0, 16'sd50);
        drain();
        // Crossed limits: above the upper one the lower check is skipped.
        setting.upper_limit = -16'sd100;
        setting.lower_limit = 16'sd100;
        setting.drive_limit = 10'd1023;
        program_regs(setting);
        send_tick(16'sd0, -16'sd5);
        send_tick(16'sd0, 16'sd5);
        drain();
        setting.drive_limit = 10'd0;
        program_regs(setting);
        send_tick(16'sd0, 16'sd1);

        for (int ph = 0; ph < 5; ph++) begin
            drain();
            if (ph == 2) idle_mode = IDLE_NONE;
            pos = sb.scaled_now();
            setting.homing_drive = 10'($urandom);
            setting.stall_speed  = 15'($urandom);
            setting.stall_ticks  = 8'($urandom);
            case (ph)
                0: begin
                    setting.drive_limit = 10'd1023;
                    setting.upper_limit = 16'sh7FFF;
                    setting.lower_limit = 16'sh8000;
                end
                1: begin
                    setting.drive_limit = 10'($urandom);
                    setting.upper_limit = 16'sh8000;
                    setting.lower_limit = 16'sh7FFF;
                end
                default: begin
                    setting.drive_limit = (ph == 4) ? 10'd400 : 10'($urandom);
                    setting.upper_limit = 16'(pos + int'($urandom_range(120)) - 60);
                    setting.lower_limit = 16'(pos + int'($urandom_range(120)) - 60);
                end
            endcase
            program_regs(setting);
            // Results back up while the sender keeps offering beats.
            if (ph == 3) want_hold = 1'b1;
            for (int i = 0; i < 100; i++) send_tick(pick_delta(), pick_command(setting.drive_limit));
        end

        drain();
        repeat (12) @(posedge aclk);
        $display("Covered %0d homing and %0d calibrated ticks over %0d register settings,",
                 sb.homing_ticks, sb.results_checked - sb.homing_ticks, settings_used);
        $display("%0d of them at a saturated position; %0d failures found.",
                 sb.saturated_ticks, sb.mismatches);
        if (sb.mismatches == 0 && sb.expected_drive_q.size() == 0) begin
            $display("[stall_homing_soft_limit_drive_unit] OK");
        end else begin
            $display("[stall_homing_soft_limit_drive_unit] ERROR");
        end
        $finish;
    end

    // Guard against a hung handshake; a normal run takes a small fraction of this.
    initial begin
        #5_000_000;
        $display("[stall_homing_soft_limit_drive_unit] ERROR");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/shsld_pkg.sv
hw/rtl/shsld_cfg.sv
hw/rtl/shsld_tracker.sv
hw/rtl/shsld_scaler.sv
hw/rtl/shsld_drive.sv
hw/rtl/stall_homing_soft_limit_drive_unit.sv
dv/tb.sv
